FILE: rtl/sndva_pkg.sv
// Shared types and constants of the sound voice allocator.
// Used by the top level sound_voice_allocator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sndva_pkg;

  localparam int ACTION_W = 3;
  localparam int ID_W     = 8;
  localparam int VOICE_W  = 5;
  localparam int LIMIT_W  = 4;
  localparam int MS_W     = 32;
  localparam int CFG_W    = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PLAY      = 3'd0,
    ACT_FINISH    = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_STOP_ALL  = 3'd3,
    ACT_SET_LIMIT = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_MUTED    = 3'd1,
    STAT_BURST    = 3'd2,
    STAT_UNKNOWN  = 3'd3,
    STAT_LIMIT    = 3'd4,
    STAT_NO_VOICE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_MUTED         = 2'd0,
    CFG_MASTER_VOLUME = 2'd1,
    CFG_DEFAULT_LIMIT = 2'd2,
    CFG_NUM_SOUNDS    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LIMIT,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_e;

  // voice priorities
  localparam logic [1:0] PRIO_UNPLACED = 2'd3;
  localparam logic [1:0] PRIO_WEAPON   = 2'd2;
  localparam logic [1:0] PRIO_OTHER    = 2'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     sound_id;
    logic                has_location;
    logic                is_weapon_fire;
    logic [VOICE_W-1:0]  voice;
    logic [LIMIT_W-1:0]  limit_value;
    logic [MS_W-1:0]     now_ms;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [VOICE_W-1:0] granted_voice;
    logic               stole;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/sndva_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sndva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/sndva_scan.sv
// Serial voice scan unit: one voice per beat, counts voices holding an id,
// tracks the lowest free voice and the lowest-index voice of least priority.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
`default_nettype none

module sndva_scan #(
  parameter int VOICES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          valid_i,
  input  wire logic [$clog2(VOICES)-1:0]     idx_i,
  input  wire logic                          busy_i,
  input  wire logic [7:0]                    sound_i,
  input  wire logic [1:0]                    prio_i,
  input  wire logic [7:0]                    id_i,
  output logic      [$clog2(VOICES+1)-1:0]   same_o,
  output logic                               free_found_o,
  output logic      [$clog2(VOICES)-1:0]     free_idx_o,
  output logic      [$clog2(VOICES)-1:0]     worst_idx_o,
  output logic      [1:0]                    worst_prio_o
);

  logic       first_q;
  logic [1:0] eff_prio;

  // an idle voice counts as priority zero
  assign eff_prio = busy_i ? prio_i : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      same_o       <= '0;
      free_found_o <= 1'b0;
      free_idx_o   <= '0;
      worst_idx_o  <= '0;
      worst_prio_o <= '0;
    end else if (start_i) begin
      first_q      <= 1'b1;
      same_o       <= '0;
      free_found_o <= 1'b0;
    end else if (valid_i) begin
      first_q <= 1'b0;
      if (busy_i && (sound_i == id_i)) begin
        same_o <= same_o + 1'b1;
      end
      if (!busy_i && !free_found_o) begin
        free_found_o <= 1'b1;
        free_idx_o   <= idx_i;
      end
      // strict less-than keeps the lowest index on ties
      if (first_q || (eff_prio < worst_prio_o)) begin
        worst_idx_o  <= idx_i;
        worst_prio_o <= eff_prio;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sound_voice_allocator.sv
// Sound voice allocator top level: sequencer, voice and id-limit state.
// Depends on sndva_pkg, sndva_ram and sndva_scan.
`timescale 1ns / 1ps
`default_nettype none

// Hands one of VOICES playback voices to each play request, or drops the
// request with a reason code; also frees voices, stops all voices and sets
// per-id voice limits. Every input beat yields exactly one result beat.
// A play beat runs through the burst and id checks plus the id-limit RAM
// read, the limit, the serial pass of the scan unit over the voice RAM (one
// voice per cycle), the voice pick and the hand-over of the result to the
// output register; a play dropped by the checks and any other action go
// straight to the hand-over, which waits until the output register is free.
// The input is ready only between beats, but a finished result may wait in
// the output register while the next beat is taken. After reset the id-limit
// RAM is cleared, one entry a cycle, over its min(MAX_IDS, 256) entries; no
// input beat is taken meanwhile, configuration writes are.
module sound_voice_allocator #(
  parameter int VOICES      = 32,
  parameter int MAX_IDS     = 256,
  parameter int BURST_LIMIT = 5
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [sndva_pkg::CFG_W-1:0] cfg_wdata_i,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire sndva_pkg::in_t              in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output sndva_pkg::out_t                  out_data_o
);

  // only ids below 256 can ever be addressed
  localparam int IDS_DEPTH = (MAX_IDS < 256) ? MAX_IDS : 256;
  localparam int ID_AW     = $clog2(IDS_DEPTH);
  localparam int VIDX_W    = $clog2(VOICES);
  localparam int CNT_W     = $clog2(VOICES + 1);
  localparam int BURST_W   = $clog2(BURST_LIMIT + 2);
  localparam int LIM_W     = sndva_pkg::LIMIT_W;

  // configuration registers
  logic                    muted_q;
  logic [7:0]              volume_q;
  logic [LIM_W-1:0]        def_limit_q;
  logic [8:0]              num_sounds_q;

  // sequencer
  sndva_pkg::state_e       state_q, state_d;
  sndva_pkg::in_t          cmd_q, cmd_d;
  sndva_pkg::out_t         res_q, res_d;
  logic [LIM_W-1:0]        lim_q, lim_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    p_vld_q, p_vld_d;
  logic [VIDX_W-1:0]       p_idx_q, p_idx_d;
  logic [ID_AW-1:0]        clr_q, clr_d;

  // voice and burst state
  logic [VOICES-1:0]       busy_q, busy_d;
  logic [31:0]             last_ms_q, last_ms_d;
  logic [BURST_W-1:0]      burst_q, burst_d;
  logic [BURST_W-1:0]      burst_next;

  // output register
  logic                    out_valid_q;
  sndva_pkg::out_t         out_q;
  logic                    out_load;

  // RAM ports
  logic                    id_we;
  logic [ID_AW-1:0]        id_waddr;
  logic [LIM_W-1:0]        id_wdata;
  logic [LIM_W-1:0]        id_rdata;
  logic                    vr_we;
  logic [VIDX_W-1:0]       vr_waddr;
  logic [9:0]              vr_wdata;
  logic [VIDX_W-1:0]       vr_raddr;
  logic [9:0]              vr_rdata;

  // scan unit
  logic                    scan_start;
  logic [CNT_W-1:0]        same_cnt;
  logic                    free_found;
  logic [VIDX_W-1:0]       free_idx;
  logic [VIDX_W-1:0]       worst_idx;
  logic [1:0]              worst_prio;

  // decode helpers
  logic                    id_known;
  logic                    voice_in_range;
  logic [1:0]              prio;
  logic                    steal_ok;
  logic [VIDX_W-1:0]       chosen;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      muted_q      <= 1'b0;
      volume_q     <= 8'd255;
      def_limit_q  <= '0;
      num_sounds_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sndva_pkg::CFG_MUTED:         muted_q      <= cfg_wdata_i[0];
        sndva_pkg::CFG_MASTER_VOLUME: volume_q     <= cfg_wdata_i[7:0];
        sndva_pkg::CFG_DEFAULT_LIMIT: def_limit_q  <= cfg_wdata_i[LIM_W-1:0];
        sndva_pkg::CFG_NUM_SOUNDS:    num_sounds_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------
  // per-id voice limit
  sndva_ram #(
    .WIDTH(LIM_W),
    .DEPTH(IDS_DEPTH)
  ) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (id_we),
    .waddr_i(id_waddr),
    .wdata_i(id_wdata),
    .raddr_i(in_data_i.sound_id[ID_AW-1:0]),
    .rdata_o(id_rdata)
  );

  // per-voice {sound id, priority}; only meaningful while the voice is busy
  sndva_ram #(
    .WIDTH(10),
    .DEPTH(VOICES)
  ) u_voice_ram (
    .clk_i  (clk_i),
    .we_i   (vr_we),
    .waddr_i(vr_waddr),
    .wdata_i(vr_wdata),
    .raddr_i(vr_raddr),
    .rdata_o(vr_rdata)
  );

  sndva_scan #(
    .VOICES(VOICES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .valid_i     (p_vld_q),
    .idx_i       (p_idx_q),
    .busy_i      (busy_q[p_idx_q]),
    .sound_i     (vr_rdata[9:2]),
    .prio_i      (vr_rdata[1:0]),
    .id_i        (cmd_q.sound_id),
    .same_o      (same_cnt),
    .free_found_o(free_found),
    .free_idx_o  (free_idx),
    .worst_idx_o (worst_idx),
    .worst_prio_o(worst_prio)
  );

  // ---------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------
  // id test at accept time uses the live input beat
  assign id_known = ({1'b0, in_data_i.sound_id} < num_sounds_q) &&
                    (32'(in_data_i.sound_id) < MAX_IDS);
  assign voice_in_range = 32'(in_data_i.voice) < VOICES;

  // same millisecond: count up, saturating one past the limit
  assign burst_next = (in_data_i.now_ms != last_ms_q) ? BURST_W'(1) :
                      (burst_q < BURST_W'(BURST_LIMIT + 1)) ? burst_q + 1'b1 :
                      burst_q;

  assign prio = !cmd_q.has_location ? sndva_pkg::PRIO_UNPLACED :
                cmd_q.is_weapon_fire ? sndva_pkg::PRIO_WEAPON :
                sndva_pkg::PRIO_OTHER;
  assign steal_ok = (prio > sndva_pkg::PRIO_OTHER) && (worst_prio < prio);
  assign chosen   = free_found ? free_idx : worst_idx;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sndva_pkg::ST_CLEAR;
      idx_q     <= '0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      clr_q     <= '0;
      busy_q    <= '0;
      last_ms_q <= '0;
      burst_q   <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      p_vld_q   <= p_vld_d;
      p_idx_q   <= p_idx_d;
      clr_q     <= clr_d;
      busy_q    <= busy_d;
      last_ms_q <= last_ms_d;
      burst_q   <= burst_d;
    end
  end

  // working payload, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
    lim_q <= lim_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    lim_d      = lim_q;
    idx_d      = idx_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    clr_d      = clr_q;
    busy_d     = busy_q;
    last_ms_d  = last_ms_q;
    burst_d    = burst_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    scan_start = 1'b0;
    id_we      = 1'b0;
    id_waddr   = in_data_i.sound_id[ID_AW-1:0];
    id_wdata   = in_data_i.limit_value;
    vr_we      = 1'b0;
    vr_waddr   = chosen;
    vr_wdata   = {cmd_q.sound_id, prio};
    vr_raddr   = idx_q[VIDX_W-1:0];

    case (state_q)
      // sweep the id-limit RAM to zero after reset
      sndva_pkg::ST_CLEAR: begin
        id_we    = 1'b1;
        id_waddr = clr_q;
        id_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == ID_AW'(IDS_DEPTH - 1)) begin
          state_d = sndva_pkg::ST_IDLE;
        end
      end

      sndva_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d        = in_data_i;
          res_d.status = sndva_pkg::STAT_DONE;
          res_d.granted_voice = '0;
          res_d.stole  = 1'b0;
          state_d      = sndva_pkg::ST_DONE;
          case (in_data_i.action)
            sndva_pkg::ACT_PLAY: begin
              if (muted_q || (volume_q == 8'd0)) begin
                res_d.status = sndva_pkg::STAT_MUTED;
              end else begin
                // a burst drop still advances the counter
                burst_d   = burst_next;
                last_ms_d = in_data_i.now_ms;
                if (burst_next > BURST_W'(BURST_LIMIT)) begin
                  res_d.status = sndva_pkg::STAT_BURST;
                end else if (!id_known) begin
                  res_d.status = sndva_pkg::STAT_UNKNOWN;
                end else begin
                  // id-limit RAM read was issued this cycle
                  state_d = sndva_pkg::ST_LIMIT;
                end
              end
            end
            sndva_pkg::ACT_FINISH, sndva_pkg::ACT_STOP: begin
              if (voice_in_range) begin
                busy_d[VIDX_W'(in_data_i.voice)] = 1'b0;
              end
            end
            sndva_pkg::ACT_STOP_ALL: begin
              busy_d = '0;
            end
            sndva_pkg::ACT_SET_LIMIT: begin
              id_we = id_known;
            end
            default: ;
          endcase
        end
      end

      // zero per-id limit falls back to the default
      sndva_pkg::ST_LIMIT: begin
        lim_d      = (id_rdata != '0) ? id_rdata : def_limit_q;
        idx_d      = '0;
        scan_start = 1'b1;
        state_d    = sndva_pkg::ST_SCAN;
      end

      // read voice idx, scan unit takes it in the next cycle
      sndva_pkg::ST_SCAN: begin
        if (32'(idx_q) < VOICES) begin
          p_vld_d = 1'b1;
          p_idx_d = idx_q[VIDX_W-1:0];
          idx_d   = idx_q + 1'b1;
        end else begin
          state_d = sndva_pkg::ST_DECIDE;
        end
      end

      sndva_pkg::ST_DECIDE: begin
        state_d = sndva_pkg::ST_DONE;
        if ((lim_q != '0) && (8'(same_cnt) >= 8'(lim_q))) begin
          res_d.status = sndva_pkg::STAT_LIMIT;
        end else if (free_found || steal_ok) begin
          res_d.status        = sndva_pkg::STAT_DONE;
          res_d.granted_voice = sndva_pkg::VOICE_W'(chosen);
          res_d.stole         = !free_found;
          busy_d[chosen]      = 1'b1;
          vr_we               = 1'b1;
        end else begin
          res_d.status = sndva_pkg::STAT_NO_VOICE;
        end
      end

      // hand the result over once the output register is free
      sndva_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = sndva_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sndva_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: verif/sound_voice_allocator_test.sv
// Self-checking testbench for the sound voice allocator: valid/ready traffic with random
// stalls on both channels, checked against a cycle-free model of voice grants.
// Depends on sndva_pkg and sound_voice_allocator.
`timescale 1ns / 1ps

module sound_voice_allocator_test;

  localparam int VOICES      = 32;
  localparam int MAX_IDS     = 256;
  localparam int BURST_LIMIT = 5;

  localparam int ACTION_W = sndva_pkg::ACTION_W;
  localparam int ID_W     = sndva_pkg::ID_W;
  localparam int VOICE_W  = sndva_pkg::VOICE_W;
  localparam int LIMIT_W  = sndva_pkg::LIMIT_W;
  localparam int MS_W     = sndva_pkg::MS_W;
  localparam int CFG_W    = sndva_pkg::CFG_W;

  // Actions past set-limit are decoded as no-ops by the block.
  localparam logic [ACTION_W-1:0] ACT_RESERVED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RESERVED_HI = 3'd7;

  localparam logic [MS_W-1:0] MS_MAX = 32'hFFFF_FFFF;
  // Settle time once the result queue is empty, beyond the length of a play.
  localparam int SETTLE_CYCLES = VOICES + 10;

  // ---------------------------------------------------------------------------
  // Grant tracker: mirrors voice ownership, id limits and the burst counter,
  // and queues the result that each accepted beat must produce.
  // ---------------------------------------------------------------------------
  class grant_tracker;
    bit                  busy[VOICES];
    logic [ID_W-1:0]     owner[VOICES];
    logic [1:0]          level[VOICES];
    logic [LIMIT_W-1:0]  id_limit[MAX_IDS];
    logic [MS_W-1:0]     last_ms;
    int unsigned         burst;
    bit                  muted;
    logic [7:0]          volume;
    logic [LIMIT_W-1:0]  def_limit;
    logic [CFG_W-1:0]    num_sounds;
    sndva_pkg::out_t     grants_due[$];
    int unsigned         fail_count;

    function new();
      foreach (busy[i]) clear_voice(i);
      foreach (id_limit[i]) id_limit[i] = '0;
      last_ms    = '0;
      burst      = 0;
      muted      = 1'b0;
      volume     = 8'd255;
      def_limit  = '0;
      num_sounds = '0;
      fail_count = 0;
    endfunction

    function void clear_voice(int v);
      busy[v]  = 1'b0;
      owner[v] = '0;
      level[v] = '0;
    endfunction

    function void apply_cfg(sndva_pkg::cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        sndva_pkg::CFG_MUTED:         muted      = data[0];
        sndva_pkg::CFG_MASTER_VOLUME: volume     = data[7:0];
        sndva_pkg::CFG_DEFAULT_LIMIT: def_limit  = data[LIMIT_W-1:0];
        sndva_pkg::CFG_NUM_SOUNDS:    num_sounds = data;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return grants_due.size();
    endfunction

    function void note_request(sndva_pkg::in_t req);
      sndva_pkg::out_t res;
      logic [LIMIT_W-1:0] lim;
      logic [1:0] want;
      int same;
      int pick;
      int weakest;
      bit found;
      bit steal;
      res = '0;
      case (req.action)
        sndva_pkg::ACT_PLAY: begin
          if (muted || volume == 0) begin
            // muted drops never touch the burst counter
            res.status = sndva_pkg::STAT_MUTED;
          end else begin
            if (req.now_ms == last_ms) begin
              if (burst < BURST_LIMIT + 1) burst++;
            end else begin
              burst = 1;
            end
            last_ms = req.now_ms;
            lim = (id_limit[req.sound_id] != 0) ? id_limit[req.sound_id] : def_limit;
            same = 0;
            for (int i = 0; i < VOICES; i++)
              if (busy[i] && owner[i] == req.sound_id) same++;
            if (!req.has_location)       want = sndva_pkg::PRIO_UNPLACED;
            else if (req.is_weapon_fire) want = sndva_pkg::PRIO_WEAPON;
            else                         want = sndva_pkg::PRIO_OTHER;
            // lowest free voice first
            found = 1'b0;
            steal = 1'b0;
            pick  = 0;
            for (int i = VOICES - 1; i >= 0; i--)
              if (!busy[i]) begin
                pick  = i;
                found = 1'b1;
              end
            // all busy: low-index voice of least priority, only if strictly weaker
            if (!found && want > sndva_pkg::PRIO_OTHER) begin
              weakest = 0;
              for (int i = 1; i < VOICES; i++)
                if (level[i] < level[weakest]) weakest = i;
              if (level[weakest] < want) begin
                pick  = weakest;
                found = 1'b1;
                steal = 1'b1;
              end
            end
            if (burst > BURST_LIMIT)             res.status = sndva_pkg::STAT_BURST;
            else if (req.sound_id >= num_sounds) res.status = sndva_pkg::STAT_UNKNOWN;
            else if (lim != 0 && same >= lim)    res.status = sndva_pkg::STAT_LIMIT;
            else if (!found)                     res.status = sndva_pkg::STAT_NO_VOICE;
            else begin
              busy[pick]        = 1'b1;
              owner[pick]       = req.sound_id;
              level[pick]       = want;
              res.granted_voice = pick[VOICE_W-1:0];
              res.stole         = steal;
            end
          end
        end
        sndva_pkg::ACT_FINISH, sndva_pkg::ACT_STOP: clear_voice(int'(req.voice));
        sndva_pkg::ACT_STOP_ALL: foreach (busy[i]) clear_voice(i);
        sndva_pkg::ACT_SET_LIMIT:
          if (req.sound_id < num_sounds) id_limit[req.sound_id] = req.limit_value;
        default: ;
      endcase
      grants_due.push_back(res);
    endfunction

    function void mismatch(string what, int unsigned want, int unsigned got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    endfunction

    function void check_result(sndva_pkg::out_t got);
      sndva_pkg::out_t want;
      if (grants_due.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual %0d/%0d/%0d",
                 $time, got.status, got.granted_voice, got.stole);
        fail_count++;
      end else begin
        want = grants_due.pop_front();
        if (got.status !== want.status)               mismatch("status", want.status, got.status);
        if (got.granted_voice !== want.granted_voice) mismatch("granted_voice",
                                                               want.granted_voice,
                                                               got.granted_voice);
        if (got.stole !== want.stole)                 mismatch("stole", want.stole, got.stole);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block and its drivers
  // ---------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_idx   = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  sndva_pkg::in_t   in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  sndva_pkg::out_t  out_data;

  grant_tracker sb;

  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_len      = 0;  // cycles the receiver still has to hold off
  logic [MS_W-1:0] ms_clock      = '0;

  always #5 clk = ~clk;

  sound_voice_allocator #(
    .VOICES      (VOICES),
    .MAX_IDS     (MAX_IDS),
    .BURST_LIMIT (BURST_LIMIT)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Both beats are observed at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic cfg_write(input sndva_pkg::cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    sb.apply_cfg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic mute, input logic [7:0] vol,
                            input logic [LIMIT_W-1:0] def_lim, input logic [CFG_W-1:0] nsnd);
    cfg_write(sndva_pkg::CFG_MUTED, CFG_W'(mute));
    cfg_write(sndva_pkg::CFG_MASTER_VOLUME, CFG_W'(vol));
    cfg_write(sndva_pkg::CFG_DEFAULT_LIMIT, CFG_W'(def_lim));
    cfg_write(sndva_pkg::CFG_NUM_SOUNDS, nsnd);
  endtask

  // Offers one beat and returns at the edge that accepts it. Valid stays up
  // across back-to-back beats; it only drops for a sender idle cycle.
  task automatic send_item(input sndva_pkg::in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sndva_pkg::in_t make_req(input logic [ACTION_W-1:0] act,
                                              input logic [ID_W-1:0] id,
                                              input logic loc, input logic weap,
                                              input logic [VOICE_W-1:0] v,
                                              input logic [LIMIT_W-1:0] lim,
                                              input logic [MS_W-1:0] ms);
    sndva_pkg::in_t r;
    r.action         = act;
    r.sound_id       = id;
    r.has_location   = loc;
    r.is_weapon_fire = weap;
    r.voice          = v;
    r.limit_value    = lim;
    r.now_ms         = ms;
    return r;
  endfunction

  // Mostly plays on a small id pool so ids collide, voices fill up and limits
  // bite; the clock often stands still so bursts build up.
  function automatic sndva_pkg::in_t random_request(input int play_pct, input int id_span);
    sndva_pkg::in_t r;
    int p;
    r = '0;
    p = $urandom_range(99);
    if (p < play_pct) r.action = sndva_pkg::ACT_PLAY;
    else begin
      p = $urandom_range(99);
      if (p < 40)      r.action = sndva_pkg::ACT_FINISH;
      else if (p < 65) r.action = sndva_pkg::ACT_STOP;
      else if (p < 68) r.action = sndva_pkg::ACT_STOP_ALL;
      else if (p < 93) r.action = sndva_pkg::ACT_SET_LIMIT;
      else             r.action = ACTION_W'($urandom_range(ACT_RESERVED_HI, ACT_RESERVED_LO));
    end
    r.sound_id = ($urandom_range(99) < 85) ? ID_W'($urandom_range(id_span - 1))
                                           : ID_W'($urandom_range(255));
    r.has_location   = 1'($urandom_range(1));
    r.is_weapon_fire = 1'($urandom_range(1));
    r.voice          = VOICE_W'($urandom_range(VOICES - 1));
    r.limit_value    = ($urandom_range(99) < 70) ? LIMIT_W'($urandom_range(3))
                                                 : LIMIT_W'($urandom_range(15));
    p = $urandom_range(99);
    if (p < 45)      ;
    else if (p < 93) ms_clock = ms_clock + $urandom_range(3, 1);
    else if (p < 97) ms_clock = $urandom();
    else             ms_clock = $urandom_range(1) ? MS_MAX : '0;
    r.now_ms = ms_clock;
    return r;
  endfunction

  task automatic run_phase(input int count, input int play_pct, input int id_span);
    for (int n = 0; n < count; n++) send_item(random_request(play_pct, id_span));
  endtask

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 8 registered ids, default limit of two per id.
    send_idle_pct = 28;
    recv_idle_pct = 62;
    set_config(1'b0, 8'd255, 4'd2, 9'd8);
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd0, 1'b0, 1'b0, 5'd0, 4'd0, '0));    // unplaced
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd0, 1'b1, 1'b1, 5'd0, 4'd0, '0));    // weapon
    // default limit hit
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd0, 1'b1, 1'b0, 5'd0, 4'd0, '0));
    send_item(make_req(sndva_pkg::ACT_SET_LIMIT, 8'd0, 1'b0, 1'b0, 5'd0, 4'd15, '0));
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd0, 1'b1, 1'b0, 5'd0, 4'd0, '0));    // own limit now
    // fifth in this ms
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd7, 1'b0, 1'b0, 5'd0, 4'd0, '0));
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd7, 1'b0, 1'b0, 5'd0, 4'd0, '0));    // burst drop
    // counter saturates
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd7, 1'b0, 1'b0, 5'd0, 4'd0, '0));
    // first unknown id
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd8, 1'b0, 1'b0, 5'd0, 4'd0, 32'd1));
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'hFF, 1'b1, 1'b1, 5'd0, 4'd0, MS_MAX));
    // ignored
    send_item(make_req(sndva_pkg::ACT_SET_LIMIT, 8'hFF, 1'b0, 1'b0, 5'd0, 4'd15, MS_MAX));
    // back to default
    send_item(make_req(sndva_pkg::ACT_SET_LIMIT, 8'd0, 1'b0, 1'b0, 5'd0, 4'd0, MS_MAX));
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd0, 1'b0, 1'b0, 5'd0, 4'd0, MS_MAX));
    send_item(make_req(sndva_pkg::ACT_FINISH, 8'd0, 1'b0, 1'b0, 5'd1, 4'd0, '0));
    // idle voice
    send_item(make_req(sndva_pkg::ACT_STOP, 8'd0, 1'b0, 1'b0, 5'(VOICES - 1), 4'd0, '0));
    send_item(make_req(sndva_pkg::ACT_STOP, 8'd0, 1'b0, 1'b0, 5'd0, 4'd0, '0));
    send_item(make_req(ACT_RESERVED_HI, 8'hFF, 1'b1, 1'b1, 5'(VOICES - 1), 4'd15, MS_MAX));
    send_item(make_req(ACT_RESERVED_LO, 8'd1, 1'b0, 1'b1, 5'd2, 4'd1, 32'd2));
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd2, 1'b1, 1'b0, 5'd0, 4'd0, 32'd5));
    send_item(make_req(sndva_pkg::ACT_STOP_ALL, 8'd0, 1'b0, 1'b0, 5'd0, 4'd0, 32'd5));
    // voice 0 again
    send_item(make_req(sndva_pkg::ACT_PLAY, 8'd3, 1'b0, 1'b0, 5'd0, 4'd0, 32'd5));
    end_burst();
    wait_quiet();

    // All ids registered, no default limit. Mid-phase the receiver stops for
    // a long stretch so the block backs up into the request channel.
    set_config(1'b0, 8'd255, 4'd0, 9'd256);
    run_phase(120, 60, 12);
    hold_len = 400;
    run_phase(180, 60, 12);
    end_burst();
    wait_quiet();

    // Muted: plays drop, everything else still acts.
    set_config(1'b1, 8'd128, 4'd3, 9'd256);
    run_phase(40, 60, 12);
    end_burst();
    wait_quiet();

    send_idle_pct = 62;
    recv_idle_pct = 28;
    // Zero master volume, default limit above its nominal range.
    set_config(1'b0, 8'd0, 4'd15, 9'd40);
    run_phase(40, 60, 40);
    end_burst();
    wait_quiet();

    set_config(1'b0, 8'd1, 4'd8, 9'd20);
    run_phase(400, 65, 22);
    end_burst();
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Nothing registered: every play and limit write is rejected.
    set_config(1'b0, 8'd200, 4'd1, 9'd0);
    run_phase(40, 60, 4);
    end_burst();
    wait_quiet();

    set_config(1'b0, 8'd255, 4'd15, 9'd12);
    run_phase(330, 65, 14);
    end_burst();
    wait_quiet();

    // Play-heavy on a wider pool: voices run out, stealing and no-voice drops.
    set_config(1'b0, 8'd255, 4'd0, 9'd256);
    run_phase(350, 85, 40);
    end_burst();
    wait_quiet();

    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
